[sv/i2cm_pkg.sv]
// shared types and constants of the i2c master byte engine
package i2cm_pkg;

  // command codes; code seven means nothing and is dropped by the front end
  typedef enum logic [2:0] {
    CMD_START    = 3'd0,
    CMD_STOP     = 3'd1,
    CMD_WRITE    = 3'd2,
    CMD_READ_ACK = 3'd3,
    CMD_READ_NAK = 3'd4,
    CMD_SELECT   = 3'd5,
    CMD_MEM      = 3'd6
  } cmd_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_ST_A   = 4'd1,
    PH_ST_B   = 4'd2,
    PH_ST_C   = 4'd3,
    PH_SP_A   = 4'd4,
    PH_SP_B   = 4'd5,
    PH_BIT_LO = 4'd6,
    PH_BIT_HI = 4'd7,
    PH_ACK_LO = 4'd8,
    PH_ACK_HI = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_CMD  = 2'd1,
    OP_DROP = 2'd2
  } op_kind_t;

  // configuration register indexes
  localparam logic [1:0] CFG_DEVICE_ADDRESS    = 2'd0;
  localparam logic [1:0] CFG_TEN_BIT_MODE      = 2'd1;
  localparam logic [1:0] CFG_LARGE_MEMORY      = 2'd2;
  localparam logic [1:0] CFG_HALF_PERIOD_TICKS = 2'd3;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd100;
  localparam logic [7:0]  TEN_BIT_PREFIX    = 8'hF0;

  typedef struct packed {
    logic        req_type;
    logic [2:0]  command;
    logic        select_read;
    logic [7:0]  write_data;
    logic [15:0] mem_address;
    logic        sda_level;
  } req_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_pull_low;
    logic       engine_busy;
    logic       command_done;
    logic       got_nak;
    logic [7:0] read_byte;
    logic       nak_error;
  } rsp_t;

  // classified beat handed from the front end to the engine
  typedef struct packed {
    op_kind_t    kind;
    cmd_t        command;
    logic        select_read;
    logic [7:0]  write_data;
    logic [15:0] mem_address;
    logic        sda_level;
  } op_t;

endpackage

[sv/i2cm_fifo.sv]
// small register queue with registered storage and occupancy count
module i2cm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] data_w,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] data_r,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign data_r  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= ptr_inc(wr_ptr);
      if (do_pop) rd_ptr <= ptr_inc(rd_ptr);
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= data_w;
  end

  a_not_full_and_empty: assert property (@(posedge clk) disable iff (rst)
    !(full && empty)) else $error("queue both full and empty");

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> !empty) else $error("queue empty after lone push");

  a_last_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push && count == CW'(1)) |=> empty)
    else $error("queue not empty after last pop");

endmodule

[sv/i2cm_front.sv]
// front end: classifies request beats and queues them for the engine
module i2cm_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  i2cm_pkg::req_t request,
  input  logic           op_pop,
  output i2cm_pkg::op_t  op,
  output logic           op_empty
);
  import i2cm_pkg::*;

  op_t             op_in;
  logic [$bits(op_t)-1:0] op_bits;

  always_comb begin
    op_in.command     = CMD_START;
    op_in.select_read = request.select_read;
    op_in.write_data  = request.write_data;
    op_in.mem_address = request.mem_address;
    op_in.sda_level   = request.sda_level;
    if (!request.req_type) begin
      op_in.kind = OP_TICK;
    end else if (request.command <= CMD_MEM) begin
      op_in.kind    = OP_CMD;
      op_in.command = cmd_t'(request.command);
    end else begin
      op_in.kind = OP_DROP;
    end
  end

  i2cm_fifo #(
    .WIDTH($bits(op_t)),
    .DEPTH(2)
  ) u_op_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .data_w(op_in),
    .full  (full),
    .pop   (op_pop),
    .data_r(op_bits),
    .empty (op_empty)
  );

  assign op = op_t'(op_bits);

endmodule

[sv/i2cm_engine.sv]
// back end: bus phase sequencer, one queued beat per cycle while the result queue has room
module i2cm_engine #(
  parameter int DELAY_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  i2cm_pkg::op_t       op,
  input  logic                op_empty,
  output logic                op_pop,
  input  logic                res_full,
  output logic                res_push,
  output i2cm_pkg::rsp_t      res
);
  import i2cm_pkg::*;

  localparam int CW = (DELAY_BITS > 16) ? DELAY_BITS : 16;

  // configuration
  logic [9:0]            dev_addr;
  logic                  ten_bit;
  logic                  large_mem;
  logic [DELAY_BITS-1:0] half_period;

  // sequencer state
  phase_t                phase, phase_next;
  logic [3:0]            bit_count, bit_count_next;
  logic [7:0]            shift_byte, shift_byte_next;
  logic [DELAY_BITS-1:0] tick_count, tick_count_next;
  cmd_t                  active_cmd, active_cmd_next;
  logic                  byte_step, byte_step_next;
  logic [7:0]            held_byte, held_byte_next;
  logic                  error_flag, error_flag_next;
  logic                  scl, scl_next;
  logic                  sda_low, sda_low_next;
  logic                  nak_seen, nak_seen_next;
  logic [7:0]            last_read, last_read_next;

  logic                  step;
  logic                  done;
  logic                  load;
  logic [7:0]            load_byte;
  logic [DELAY_BITS:0]   tick_inc;
  logic [7:0]            shifted;
  logic [3:0]            bit_inc;

  function automatic logic [DELAY_BITS-1:0] sat_half(input logic [15:0] v);
    logic [CW-1:0] w;
    logic [CW-1:0] lim;
    w   = CW'(v);
    lim = CW'({DELAY_BITS{1'b1}});
    if (w == '0) w = CW'(1);
    if (w > lim) w = lim;
    return w[DELAY_BITS-1:0];
  endfunction

  function automatic logic is_read(input cmd_t c);
    return (c == CMD_READ_ACK) || (c == CMD_READ_NAK);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_addr    <= '0;
      ten_bit     <= 1'b0;
      large_mem   <= 1'b0;
      half_period <= sat_half(HALF_PERIOD_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEVICE_ADDRESS:    dev_addr <= cfg_data[9:0];
        CFG_TEN_BIT_MODE:      ten_bit <= cfg_data[0];
        CFG_LARGE_MEMORY:      large_mem <= cfg_data[0];
        CFG_HALF_PERIOD_TICKS: half_period <= sat_half(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bit_count  <= '0;
      shift_byte <= '0;
      tick_count <= '0;
      active_cmd <= CMD_START;
      byte_step  <= 1'b0;
      held_byte  <= '0;
      error_flag <= 1'b0;
      scl        <= 1'b1;
      sda_low    <= 1'b0;
      nak_seen   <= 1'b0;
      last_read  <= '0;
    end else if (step) begin
      phase      <= phase_next;
      bit_count  <= bit_count_next;
      shift_byte <= shift_byte_next;
      tick_count <= tick_count_next;
      active_cmd <= active_cmd_next;
      byte_step  <= byte_step_next;
      held_byte  <= held_byte_next;
      error_flag <= error_flag_next;
      scl        <= scl_next;
      sda_low    <= sda_low_next;
      nak_seen   <= nak_seen_next;
      last_read  <= last_read_next;
    end
  end

  assign step     = ~op_empty & ~res_full;
  assign op_pop   = step;
  assign res_push = step;
  assign tick_inc = {1'b0, tick_count} + 1'b1;
  assign shifted  = {shift_byte[6:0], 1'b0};
  assign bit_inc  = bit_count + 1'b1;

  always_comb begin
    phase_next      = phase;
    bit_count_next  = bit_count;
    shift_byte_next = shift_byte;
    tick_count_next = tick_count;
    active_cmd_next = active_cmd;
    byte_step_next  = byte_step;
    held_byte_next  = held_byte;
    error_flag_next = error_flag;
    scl_next        = scl;
    sda_low_next    = sda_low;
    nak_seen_next   = nak_seen;
    last_read_next  = last_read;
    done            = 1'b0;
    load            = 1'b0;
    load_byte       = '0;

    if (op.kind == OP_CMD && phase == PH_IDLE) begin
      // command accepted: latch operands and enter the first phase
      active_cmd_next = op.command;
      tick_count_next = '0;
      byte_step_next  = 1'b0;
      held_byte_next  = '0;
      unique case (op.command)
        CMD_START: begin
          error_flag_next = 1'b0;
          phase_next      = PH_ST_A;
          scl_next        = 1'b1;
          sda_low_next    = 1'b0;
        end
        CMD_STOP: begin
          phase_next   = PH_SP_A;
          scl_next     = 1'b0;
          sda_low_next = 1'b1;
        end
        CMD_WRITE: begin
          load      = 1'b1;
          load_byte = op.write_data;
        end
        CMD_READ_ACK, CMD_READ_NAK: begin
          load = 1'b1;
        end
        CMD_SELECT: begin
          load = 1'b1;
          if (ten_bit) begin
            held_byte_next = dev_addr[7:0];
            byte_step_next = 1'b1;
            load_byte      = TEN_BIT_PREFIX | {5'b0, dev_addr[9:8], op.select_read};
          end else begin
            load_byte = {dev_addr[6:0], op.select_read};
          end
        end
        CMD_MEM: begin
          load = 1'b1;
          if (large_mem) begin
            held_byte_next = op.mem_address[7:0];
            byte_step_next = 1'b1;
            load_byte      = op.mem_address[15:8];
          end else begin
            load_byte = op.mem_address[7:0];
          end
        end
        default: ;
      endcase
    end else if (op.kind == OP_TICK && phase != PH_IDLE) begin
      if (tick_inc >= {1'b0, half_period}) begin
        // phase over
        tick_count_next = '0;
        unique case (phase)
          PH_ST_A: begin
            phase_next   = PH_ST_B;
            sda_low_next = 1'b1;
          end
          PH_ST_B: begin
            phase_next = PH_ST_C;
            scl_next   = 1'b0;
          end
          PH_ST_C: done = 1'b1;
          PH_SP_A: begin
            phase_next = PH_SP_B;
            scl_next   = 1'b1;
          end
          PH_SP_B: begin
            sda_low_next = 1'b0;
            done         = 1'b1;
          end
          PH_BIT_LO: begin
            if (is_read(active_cmd)) shift_byte_next = {shift_byte[6:0], op.sda_level};
            phase_next = PH_BIT_HI;
            scl_next   = 1'b1;
          end
          PH_BIT_HI: begin
            if (!is_read(active_cmd)) shift_byte_next = shifted;
            bit_count_next = bit_inc;
            scl_next       = 1'b0;
            if (bit_inc >= 4'd8) begin
              phase_next   = PH_ACK_LO;
              sda_low_next = (active_cmd == CMD_READ_ACK);
            end else begin
              phase_next   = PH_BIT_LO;
              sda_low_next = is_read(active_cmd) ? 1'b0 : ~shifted[7];
            end
          end
          PH_ACK_LO: begin
            scl_next = 1'b1;
            if (is_read(active_cmd)) begin
              phase_next = PH_ACK_HI;
            end else begin
              nak_seen_next = op.sda_level;
              if (op.sda_level) begin
                error_flag_next = 1'b1;
                done            = 1'b1;
              end else if (byte_step) begin
                byte_step_next = 1'b0;
                load           = 1'b1;
                load_byte      = held_byte;
              end else begin
                done = 1'b1;
              end
            end
          end
          PH_ACK_HI: begin
            last_read_next = shift_byte;
            done           = 1'b1;
          end
          default: done = 1'b1;
        endcase
      end else begin
        tick_count_next = tick_inc[DELAY_BITS-1:0];
      end
    end

    // start of a byte: first data bit with scl low
    if (load) begin
      shift_byte_next = load_byte;
      bit_count_next  = '0;
      phase_next      = PH_BIT_LO;
      scl_next        = 1'b0;
      sda_low_next    = is_read(active_cmd_next) ? 1'b0 : ~load_byte[7];
    end
    if (done) phase_next = PH_IDLE;
  end

  always_comb begin
    res.scl_level    = scl_next;
    res.sda_pull_low = sda_low_next;
    res.engine_busy  = (phase_next != PH_IDLE);
    res.command_done = done;
    res.got_nak      = nak_seen_next;
    res.read_byte    = last_read_next;
    res.nak_error    = error_flag_next;
  end

  a_bit_count_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BIT_LO || phase == PH_BIT_HI) |-> bit_count < 4'd8)
    else $error("bit counter past byte end in a data phase");

  a_error_from_ack: assert property (@(posedge clk) disable iff (rst)
    $rose(error_flag) |-> $past(phase) == PH_ACK_LO)
    else $error("error flag set outside ack phase");

  a_done_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (step && done) |=> phase == PH_IDLE)
    else $error("finished command left engine busy");

endmodule

[sv/i2c_master_byte_engine.sv]
// top level of the i2c master byte engine: front end, engine and result queue
//
// bit-banged i2c master. each request beat is either a bus tick or a command
// (start, stop, write byte, read byte with ack or nak, device select in 7-bit
// or 10-bit form, memory address of one or two bytes); commands are taken only
// while the engine is idle and are otherwise ignored. every request beat gives
// exactly one result beat with the pin levels and status as they stand after
// it. each scl/sda phase lasts half_period_ticks ticks (zero counts as one,
// values above 2**DELAY_BITS-1 saturate). throughput is one beat per clock:
// the engine updates its counters and phase as each beat is taken, so a tick or a
// command can be pushed every cycle as long as results are popped. a result
// passes through the request queue and then the result queue, and can be
// popped once it shows on the result ports. when results are not popped the
// result queue fills, the engine holds, and the request queue fills behind it
// and raises full. configuration is written through cfg_we/cfg_index/cfg_data
// and must only change while both queues are drained.
module i2c_master_byte_engine #(
  parameter int DELAY_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  // request side
  input  logic           push,
  output logic           full,
  input  i2cm_pkg::req_t request,
  // result side
  output logic           empty,
  input  logic           pop,
  output i2cm_pkg::rsp_t result,
  // configuration writes
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_data
);
  import i2cm_pkg::*;

  op_t  op;
  logic op_empty;
  logic op_pop;
  rsp_t res;
  logic res_push;
  logic res_full;
  logic [$bits(rsp_t)-1:0] res_bits;

  // classification and request queue
  i2cm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .request (request),
    .op_pop  (op_pop),
    .op      (op),
    .op_empty(op_empty)
  );

  // phase sequencer, steps once per queued beat when the result queue has room
  i2cm_engine #(
    .DELAY_BITS(DELAY_BITS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .op       (op),
    .op_empty (op_empty),
    .op_pop   (op_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res)
  );

  // result queue decouples the engine from the consumer
  i2cm_fifo #(
    .WIDTH($bits(rsp_t)),
    .DEPTH(2)
  ) u_result_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .data_w(res),
    .full  (res_full),
    .pop   (pop),
    .data_r(res_bits),
    .empty (empty)
  );

  assign result = rsp_t'(res_bits);

endmodule
